>>> design/skvt_pkg.sv
// ----------------------------------------------------------------------------
// Sorted key/value table: shared definitions
// Field widths, operation and status codes, controller states and the
// command/status bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package skvt_pkg;

   localparam int unsigned SKVT_CAPACITY = 256;

   localparam int unsigned MODE_W  = 2;
   localparam int unsigned KEY_W   = 64;
   localparam int unsigned VALUE_W = 64;
   localparam int unsigned STAT_W  = 2;
   localparam int unsigned SLOT_W  = 9;

   // packed port widths
   localparam int unsigned REQ_DATA_W = 128;
   localparam int unsigned RSP_DATA_W = 88;

   typedef enum logic [MODE_W-1:0] {
      MODE_CLEAR = 2'd0,
      MODE_ADD   = 2'd1,
      MODE_READ  = 2'd2,
      MODE_WRITE = 2'd3
   } mode_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK   = 2'd0,
      STAT_MISS = 2'd1,
      STAT_FULL = 2'd2,
      STAT_RSVD = 2'd3
   } rsp_status_type;

   // what the pending word reports once the operation completes
   typedef enum logic [2:0] {
      RES_CLEAR,
      RES_HIT,
      RES_WRITE,
      RES_NEW,
      RES_MISS,
      RES_FULL
   } result_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SEARCH_CMP,
      ST_CHECK,
      ST_SHIFT,
      ST_INSERT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic       load;
      logic       clear;
      logic       search_read;
      logic       search_step;
      logic       check_read;
      logic       write_value;
      logic       shift_init;
      logic       shift_step;
      logic       insert;
      logic       set_result;
      result_type result;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     search_open;
      logic     hit;
      logic     full;
      logic     shift_busy;
      logic     rsp_free;
   } stat_type;

   // flip the sign bit so unsigned order matches signed order
   function automatic logic [KEY_W-1:0] bias_key(input logic [KEY_W-1:0] k);
      bias_key = {~k[KEY_W-1], k[KEY_W-2:0]};
   endfunction

endpackage

>>> design/skvt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data held when not read.
// ----------------------------------------------------------------------------
module skvt_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, hold last word when idle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/skvt_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted key/value table: controller
// Sequences one request: a clear, or binary search, hit check and
// shift-and-insert, then hand-off of the result word to the output register.
// ----------------------------------------------------------------------------
module skvt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  skvt_pkg::stat_type stat,
   output skvt_pkg::cmd_type  cmd
);

   import skvt_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            priority if (stat.mode == MODE_CLEAR) begin
               cmd.clear      = 1'b1;
               cmd.set_result = 1'b1;
               cmd.result     = RES_CLEAR;
               state_in       = ST_EMIT;
            end else if (stat.search_open) begin
               cmd.search_read = 1'b1;
               state_in        = ST_SEARCH_CMP;
            end else begin
               cmd.check_read = 1'b1;
               state_in       = ST_CHECK;
            end
         end
         ST_SEARCH_CMP: begin
            cmd.search_step = 1'b1;
            state_in        = ST_SEARCH;
         end
         ST_CHECK: begin
            cmd.set_result = 1'b1;
            state_in       = ST_EMIT;
            priority if (stat.mode == MODE_ADD) begin
               priority if (stat.hit) begin
                  cmd.result = RES_HIT;
               end else if (stat.full) begin
                  cmd.result = RES_FULL;
               end else begin
                  cmd.result     = RES_NEW;
                  cmd.shift_init = 1'b1;
                  state_in       = ST_SHIFT;
               end
            end else if (!stat.hit) begin
               cmd.result = RES_MISS;
            end else if (stat.mode == MODE_WRITE) begin
               cmd.result      = RES_WRITE;
               cmd.write_value = 1'b1;
            end else begin
               cmd.result = RES_HIT;
            end
         end
         ST_SHIFT: begin
            cmd.shift_step = 1'b1;
            if (!stat.shift_busy) begin
               state_in = ST_INSERT;
            end
         end
         ST_INSERT: begin
            cmd.insert = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> design/skvt_datapath.sv
// ----------------------------------------------------------------------------
// Sorted key/value table: datapath
// Request capture, search bounds, entry count, shift pointers, the key and
// value memories and the output register.
// ----------------------------------------------------------------------------
module skvt_datapath #(
   parameter int unsigned CAPACITY = skvt_pkg::SKVT_CAPACITY
) (
   input  logic                              clock,
   input  logic                              reset,
   input  skvt_pkg::cmd_type                 cmd,
   output skvt_pkg::stat_type                stat,
   input  logic [skvt_pkg::MODE_W-1:0]       req_mode,
   input  logic [skvt_pkg::KEY_W-1:0]        req_key,
   input  logic [skvt_pkg::VALUE_W-1:0]      req_new_value,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [skvt_pkg::STAT_W-1:0]       rsp_status,
   output logic [skvt_pkg::SLOT_W-1:0]       rsp_slot,
   output logic [skvt_pkg::VALUE_W-1:0]      rsp_value_out,
   output logic [skvt_pkg::SLOT_W-1:0]       rsp_entry_count
);

   import skvt_pkg::*;

   localparam int unsigned IW = $clog2(CAPACITY);
   localparam int unsigned CW = $clog2(CAPACITY + 1);

   // captured request
   mode_type           mode_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [VALUE_W-1:0] nv_ff;

   // search bounds and table fill
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [CW-1:0] count_ff, count_in;

   // shift pointers
   logic [IW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [IW-1:0] wr_addr_ff, wr_addr_in;
   logic          rd_active_ff, rd_active_in;
   logic          pend_ff, pend_in;

   result_type res_ff;

   // output register
   logic               rsp_valid_ff;
   rsp_status_type     rsp_status_ff;
   logic [SLOT_W-1:0]  rsp_slot_ff;
   logic [VALUE_W-1:0] rsp_value_ff;
   logic [SLOT_W-1:0]  rsp_count_ff;

   // memory ports
   logic               key_wr_en, val_wr_en, rd_en;
   logic [IW-1:0]      key_wr_addr, val_wr_addr, rd_addr;
   logic [KEY_W-1:0]   key_wr_data, rd_key;
   logic [VALUE_W-1:0] val_wr_data, rd_val;

   logic [CW-1:0]      diff, mid_full, count_m1;
   logic [IW-1:0]      mid;
   logic               shift_wr;
   logic [CW+SLOT_W-1:0] slot_ext, count_ext;

   // midpoint of the open search range
   assign diff     = hi_ff - lo_ff;
   assign mid_full = lo_ff + (diff >> 1);
   assign mid      = mid_full[IW-1:0];
   assign count_m1 = count_ff - 1'b1;
   assign shift_wr = cmd.shift_step && pend_ff;

   // capture request, biased key for unsigned compare
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= mode_type'(req_mode);
         key_ff  <= bias_key(req_key);
         nv_ff   <= req_new_value;
      end
      if (cmd.set_result) begin
         res_ff <= cmd.result;
      end
   end

   // bounds, count and shift pointer updates
   always_comb begin
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      count_in     = count_ff;
      rd_ptr_in    = rd_ptr_ff;
      wr_addr_in   = wr_addr_ff;
      rd_active_in = rd_active_ff;
      pend_in      = pend_ff;
      if (cmd.load) begin
         lo_in = '0;
         hi_in = count_ff;
      end
      if (cmd.search_step) begin
         if (rd_key < key_ff) begin
            lo_in = mid_full + 1'b1;
         end else begin
            hi_in = mid_full;
         end
      end
      if (cmd.clear) begin
         count_in = '0;
      end
      if (cmd.insert) begin
         count_in = count_ff + 1'b1;
      end
      if (cmd.shift_init) begin
         rd_ptr_in    = count_m1[IW-1:0];
         rd_active_in = (count_ff != lo_ff);
         pend_in      = 1'b0;
      end
      if (cmd.shift_step) begin
         pend_in = rd_active_ff;
         if (rd_active_ff) begin
            wr_addr_in   = rd_ptr_ff + 1'b1;
            rd_ptr_in    = rd_ptr_ff - 1'b1;
            rd_active_in = (rd_ptr_ff != lo_ff[IW-1:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_active_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rd_active_ff <= rd_active_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      rd_ptr_ff  <= rd_ptr_in;
      wr_addr_ff <= wr_addr_in;
   end

   // memory address and data selection
   always_comb begin
      rd_en       = 1'b0;
      rd_addr     = lo_ff[IW-1:0];
      key_wr_en   = 1'b0;
      val_wr_en   = 1'b0;
      key_wr_addr = lo_ff[IW-1:0];
      val_wr_addr = lo_ff[IW-1:0];
      key_wr_data = key_ff;
      val_wr_data = '0;
      if (cmd.search_read) begin
         rd_en   = 1'b1;
         rd_addr = mid;
      end
      if (cmd.check_read) begin
         rd_en = 1'b1;
      end
      if (cmd.shift_step && rd_active_ff) begin
         rd_en   = 1'b1;
         rd_addr = rd_ptr_ff;
      end
      if (shift_wr) begin
         key_wr_en   = 1'b1;
         val_wr_en   = 1'b1;
         key_wr_addr = wr_addr_ff;
         val_wr_addr = wr_addr_ff;
         key_wr_data = rd_key;
         val_wr_data = rd_val;
      end
      if (cmd.insert) begin
         key_wr_en = 1'b1;
         val_wr_en = 1'b1;
      end
      if (cmd.write_value) begin
         val_wr_en   = 1'b1;
         val_wr_data = nv_ff;
      end
   end

   skvt_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (key_wr_addr),
      .wr_data (key_wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_key)
   );

   skvt_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_value_ram (
      .clock   (clock),
      .wr_en   (val_wr_en),
      .wr_addr (val_wr_addr),
      .wr_data (val_wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_val)
   );

   // status back to the controller
   always_comb begin
      stat             = '0;
      stat.mode        = mode_ff;
      stat.search_open = (lo_ff < hi_ff);
      stat.hit         = (lo_ff < count_ff) && (rd_key == key_ff);
      stat.full        = (count_ff == CW'(CAPACITY));
      stat.shift_busy  = rd_active_ff || pend_ff;
      stat.rsp_free    = !rsp_valid_ff || rsp_tready;
   end

   // fold slot and count into the 9-bit result fields
   assign slot_ext  = {{SLOT_W{1'b0}}, lo_ff};
   assign count_ext = {{SLOT_W{1'b0}}, count_ff};

   // output register: load on emit, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_count_ff <= count_ext[SLOT_W-1:0];
         unique case (res_ff)
            RES_CLEAR: begin
               rsp_status_ff <= STAT_OK;
               rsp_slot_ff   <= '0;
               rsp_value_ff  <= '0;
            end
            RES_HIT: begin
               rsp_status_ff <= STAT_OK;
               rsp_slot_ff   <= slot_ext[SLOT_W-1:0];
               rsp_value_ff  <= rd_val;
            end
            RES_WRITE: begin
               rsp_status_ff <= STAT_OK;
               rsp_slot_ff   <= slot_ext[SLOT_W-1:0];
               rsp_value_ff  <= nv_ff;
            end
            RES_NEW: begin
               rsp_status_ff <= STAT_OK;
               rsp_slot_ff   <= slot_ext[SLOT_W-1:0];
               rsp_value_ff  <= '0;
            end
            RES_MISS: begin
               rsp_status_ff <= STAT_MISS;
               rsp_slot_ff   <= slot_ext[SLOT_W-1:0];
               rsp_value_ff  <= '0;
            end
            RES_FULL: begin
               rsp_status_ff <= STAT_FULL;
               rsp_slot_ff   <= slot_ext[SLOT_W-1:0];
               rsp_value_ff  <= '0;
            end
            default: begin
               rsp_status_ff <= STAT_OK;
               rsp_slot_ff   <= '0;
               rsp_value_ff  <= '0;
            end
         endcase
      end
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_value_out   = rsp_value_ff;
   assign rsp_entry_count = rsp_count_ff;

   // table never overfills
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   // insert only into a table with room
   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |-> (count_ff < CW'(CAPACITY)))
      else $error("insert into full table");

   // a new word never overwrites one still waiting
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_tready))
      else $error("result word overwritten");

   // shift write and read never hit the same entry
   a_shift_addr: assert property (@(posedge clock) disable iff (reset)
      (shift_wr && rd_active_ff) |-> (wr_addr_ff != rd_ptr_ff))
      else $error("shift read and write collide");

endmodule

>>> design/sorted_key_value_table_unit.sv
// ----------------------------------------------------------------------------
// Sorted key/value table unit
// Holds distinct signed keys in ascending order, each with a value; supports
// clear, add key, read by key and write by key with lower-bound search.
//
//   channel  dir  ports         word contents
//   req      in   req_t*        tuser: mode; tdata: key, new_value
//   rsp      out  rsp_t*        tuser: status; tdata: slot, value_out, count
//
// One request at a time; a new request is taken while the previous result
// word still waits in the output register.
// Read/write: the lower-bound search does one key-memory read and one compare
// per search step, then a hit check.
// Add of a new key: that plus a shift, one entry a cycle, of the entries at and
// above the slot through the key and value memories.
// Reset empties the table at once; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_key_value_table_unit #(
   parameter int unsigned CAPACITY = skvt_pkg::SKVT_CAPACITY
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [1:0] mode
   input  logic [skvt_pkg::MODE_W-1:0]         req_tuser,
   // [63:0] key, [127:64] new_value
   input  logic [skvt_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [1:0] status
   output logic [skvt_pkg::STAT_W-1:0]         rsp_tuser,
   // [8:0] slot, [72:9] value_out, [81:73] entry_count, [87:82] zero
   output logic [skvt_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   import skvt_pkg::*;

   cmd_type            cmd;
   stat_type           stat;
   logic [SLOT_W-1:0]  slot;
   logic [VALUE_W-1:0] value_out;
   logic [SLOT_W-1:0]  entry_count;

   skvt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   skvt_datapath #(.CAPACITY(CAPACITY)) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_mode        (req_tuser),
      .req_key         (req_tdata[KEY_W-1:0]),
      .req_new_value   (req_tdata[KEY_W+VALUE_W-1:KEY_W]),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_status      (rsp_tuser),
      .rsp_slot        (slot),
      .rsp_value_out   (value_out),
      .rsp_entry_count (entry_count)
   );

   // pack result word, pad to whole bytes
   assign rsp_tdata = {{(RSP_DATA_W - 2*SLOT_W - VALUE_W){1'b0}},
                       entry_count, value_out, slot};

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// Sorted key/value table unit: testbench
// Drives clear, add, read and write words into the unit and checks every
// result word against a behavioral table kept in the testbench. It covers
// directed corner cases, a fill to capacity, a long output stall and random
// traffic with idle gaps on both sides. The tail of the run has no gaps.
// ----------------------------------------------------------------------------
module tb;
   import skvt_pkg::*;

   localparam int unsigned CAPACITY    = SKVT_CAPACITY;
   localparam int unsigned CYCLE_LIMIT = 3000000;
   localparam int unsigned DRAIN_WAIT  = 300;
   localparam int unsigned LONG_STALL  = 400;

   localparam logic [63:0] KEY_MIN = 64'h8000_0000_0000_0000;
   localparam logic [63:0] KEY_MAX = 64'h7fff_ffff_ffff_ffff;
   localparam logic [63:0] ALL_ONE = 64'hffff_ffff_ffff_ffff;

   typedef struct {
      rsp_status_type status;
      logic [8:0]     slot;
      logic [63:0]    value;
      logic [8:0]     count;
   } table_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [MODE_W-1:0]     req_tuser = '0;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [STAT_W-1:0]     rsp_tuser;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // behavioral copy of the table
   logic signed [63:0] tbl_key [0:CAPACITY-1];
   logic [63:0]        tbl_val [0:CAPACITY-1];
   int unsigned        tbl_count = 0;

   table_result_type pending_results[$];
   int unsigned      fail_count = 0;
   bit               req_gaps   = 1'b1;
   bit               rsp_gaps   = 1'b1;
   bit               long_hold  = 1'b0;

   sorted_key_value_table_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // abort a hung run
   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // apply one word to the table and return the result it must produce
   function automatic table_result_type table_model_step(mode_type m, logic [63:0] k,
                                                         logic [63:0] nv);
      table_result_type r;
      int unsigned      pos;
      bit               hit;
      r.status = STAT_OK;
      r.slot   = '0;
      r.value  = '0;
      if (m == MODE_CLEAR) begin
         tbl_count = 0;
      end else begin
         // lower bound by linear scan
         pos = 0;
         while (pos < tbl_count && tbl_key[pos] < $signed(k)) pos++;
         hit = (pos < tbl_count) && (tbl_key[pos] == $signed(k));
         r.slot = 9'(pos);
         if (m == MODE_ADD) begin
            if (hit) begin
               r.value = tbl_val[pos];
            end else if (tbl_count >= CAPACITY) begin
               r.status = STAT_FULL;
            end else begin
               for (int i = int'(tbl_count); i > int'(pos); i--) begin
                  tbl_key[i] = tbl_key[i-1];
                  tbl_val[i] = tbl_val[i-1];
               end
               tbl_key[pos] = $signed(k);
               tbl_val[pos] = '0;
               tbl_count++;
            end
         end else if (!hit) begin
            r.status = STAT_MISS;
         end else begin
            if (m == MODE_WRITE) tbl_val[pos] = nv;
            r.value = tbl_val[pos];
         end
      end
      r.count = 9'(tbl_count);
      return r;
   endfunction

   // offer one word, hold it until taken, then log its expected result
   task automatic send_word(mode_type m, logic [63:0] k, logic [63:0] nv);
      table_result_type predicted;
      if (req_gaps && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= m;
      req_tdata  <= {nv, k};
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      predicted = table_model_step(m, k, nv);
      pending_results.insert(pending_results.size(), predicted);
   endtask

   // choose a key: often one held in the table or next to one, else small or wide
   function automatic logic [63:0] pick_key(int unsigned present_pct);
      logic [63:0] k;
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (tbl_count != 0 && roll < present_pct) begin
         k = tbl_key[$urandom_range(0, tbl_count - 1)];
         if ($urandom_range(0, 3) == 0) k = k + ($urandom_range(0, 1) ? 64'd1 : ALL_ONE);
      end else if (roll < present_pct + 15) begin
         k = 64'(int'($urandom_range(0, 32)) - 16);
      end else begin
         k = {$urandom, $urandom};
      end
      return k;
   endfunction

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   task automatic note_mismatch(string field, logic [63:0] want, logic [63:0] got);
      fail_count++;
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
   endtask

   // compare a taken result word with the oldest expectation
   task automatic check_result();
      table_result_type want;
      if (pending_results.size() == 0) begin
         fail_count++;
         $error("result word with nothing outstanding: tuser 0x%0h tdata 0x%0h",
                rsp_tuser, rsp_tdata);
      end else begin
         want = pending_results.pop_front();
         if (rsp_tuser !== want.status)
            note_mismatch("status", 64'(want.status), 64'(rsp_tuser));
         if (rsp_tdata[8:0] !== want.slot)
            note_mismatch("slot", 64'(want.slot), 64'(rsp_tdata[8:0]));
         if (rsp_tdata[72:9] !== want.value)
            note_mismatch("value_out", want.value, rsp_tdata[72:9]);
         if (rsp_tdata[81:73] !== want.count)
            note_mismatch("entry_count", 64'(want.count), 64'(rsp_tdata[81:73]));
      end
   endtask

   // result side: check taken words and stall in bursts or one long hold
   initial begin : rsp_side
      int unsigned stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) check_result();
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (long_hold) begin
            long_hold  = 1'b0;
            stall_left = LONG_STALL - 1;
            rsp_tready <= 1'b0;
         end else if (rsp_gaps && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 18) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // corner cases: empty table, extreme keys and values, hits, misses, duplicates
   task automatic test_directed();
      send_word(MODE_CLEAR, ALL_ONE, ALL_ONE);
      send_word(MODE_READ, 64'd0, 64'd0);
      send_word(MODE_WRITE, KEY_MIN, ALL_ONE);
      send_word(MODE_ADD, 64'd0, ALL_ONE);
      send_word(MODE_ADD, KEY_MAX, 64'd0);
      send_word(MODE_ADD, KEY_MIN, 64'd0);
      send_word(MODE_ADD, ALL_ONE, 64'd0);
      send_word(MODE_ADD, 64'd0, 64'd0);
      send_word(MODE_WRITE, KEY_MAX, ALL_ONE);
      send_word(MODE_WRITE, KEY_MIN, KEY_MIN);
      send_word(MODE_WRITE, 64'd0, KEY_MAX);
      send_word(MODE_READ, KEY_MAX, 64'd0);
      send_word(MODE_READ, KEY_MIN, 64'd0);
      send_word(MODE_READ, 64'd0, 64'd0);
      send_word(MODE_ADD, KEY_MAX, 64'd0);
      send_word(MODE_READ, 64'd5, 64'd0);
      send_word(MODE_WRITE, 64'd5, ALL_ONE);
      send_word(MODE_READ, KEY_MAX - 64'd1, 64'd0);
      send_word(MODE_WRITE, ALL_ONE, 64'h5555_5555_5555_5555);
      send_word(MODE_WRITE, ALL_ONE, 64'haaaa_aaaa_aaaa_aaaa);
      send_word(MODE_READ, ALL_ONE, 64'd0);
      send_word(MODE_CLEAR, 64'd0, 64'd0);
      send_word(MODE_READ, KEY_MAX, 64'd0);
   endtask

   // fill to capacity, then add, read and write against the full table
   task automatic test_fill();
      send_word(MODE_CLEAR, 64'd0, 64'd0);
      while (tbl_count < CAPACITY) send_word(MODE_ADD, rand_word(), rand_word());
      send_word(MODE_ADD, rand_word(), 64'd0);
      send_word(MODE_ADD, tbl_key[CAPACITY-1], 64'd0);
      send_word(MODE_ADD, tbl_key[0], 64'd0);
      send_word(MODE_WRITE, tbl_key[CAPACITY-1], rand_word());
      send_word(MODE_READ, tbl_key[CAPACITY-1], 64'd0);
      send_word(MODE_WRITE, tbl_key[0], rand_word());
      send_word(MODE_READ, tbl_key[CAPACITY/2], 64'd0);
      send_word(MODE_WRITE, rand_word(), rand_word());
      send_word(MODE_ADD, tbl_key[CAPACITY/2] + 64'd1, 64'd0);
      send_word(MODE_CLEAR, 64'd0, 64'd0);
   endtask

   // hold the result side for a long stretch while words keep coming
   task automatic test_backpressure();
      req_gaps  = 1'b0;
      long_hold = 1'b1;
      for (int i = 0; i < 40; i++) begin
         if (i % 3 == 2) send_word(MODE_READ, pick_key(70), 64'd0);
         else            send_word(MODE_ADD, pick_key(20), rand_word());
      end
      req_gaps = 1'b1;
   endtask

   // mostly well-formed traffic on held keys, with some noise and rare clears
   task automatic test_random(int unsigned n_words);
      int unsigned roll;
      for (int i = 0; i < int'(n_words); i++) begin
         roll = $urandom_range(0, 999);
         if (roll < 6)
            send_word(MODE_CLEAR, rand_word(), rand_word());
         else if (roll < 406)
            send_word(MODE_ADD, pick_key(25), rand_word());
         else if (roll < 676)
            send_word(MODE_READ, pick_key(75), rand_word());
         else if (roll < 946)
            send_word(MODE_WRITE, pick_key(75), rand_word());
         else
            send_word(mode_type'($urandom_range(1, 3)), rand_word(), rand_word());
      end
   endtask

   initial begin : main
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_fill();
      test_backpressure();
      test_random(1420);
      // tail of the run: no gaps on either side
      req_gaps = 1'b0;
      rsp_gaps = 1'b0;
      test_random(100);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
